// File: design/dti_pkg.sv
package dti_pkg;

    // store geometry
    localparam int HELD_DEPTH = 16;
    localparam int CNT_W      = $clog2(HELD_DEPTH + 1);
    localparam int IDX_W      = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
    localparam int DVS_W      = $clog2(HELD_DEPTH + 2);

    // field widths
    localparam int STAMP_W = 32;
    localparam int POS_W   = 31;
    localparam int SIZE_W  = 24;

    // divider iteration counter holds 0..STAMP_W
    localparam int DIV_CNT_W = $clog2(STAMP_W + 1);

    localparam logic [STAMP_W-1:0] STAMP_SENTINEL = '1;

    // operation codes
    localparam logic OP_ENTRY = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [SIZE_W-1:0] size;
        logic              key;
    } t_held;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_EMIT,
        S_LAST
    } t_state;

endpackage

// File: design/dti_div.sv
module dti_div import dti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [STAMP_W-1:0] i_dividend,
    input  logic [DVS_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [STAMP_W-1:0] o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0]     r_rem, n_rem;
    logic [DVS_W-1:0]     r_dvs, n_dvs;
    logic [STAMP_W-1:0]   r_quo, n_quo;
    logic [DVS_W:0]       trial;
    logic                 qbit;

    // restoring divide, one quotient bit per cycle
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        trial  = {r_rem, r_quo[STAMP_W-1]};
        qbit   = (trial >= {1'b0, r_dvs});
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(STAMP_W);
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            n_rem = qbit ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
            n_quo = {r_quo[STAMP_W-2:0], qbit};
            n_cnt = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: design/dti_held_mem.sv
module dti_held_mem import dti_pkg::*; (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_held            i_wr_data,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_held            o_rd_data
);

    t_held r_mem [HELD_DEPTH];
    t_held r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/duplicate_timestamp_interpolator.sv
// operation: a repeated-stamp entry or a flush is absorbed in the accept cycle; a lone or
//   dropped entry goes to S_LAST, which registers its result; with n held entries the
//   32-step serial divider runs first, then S_RD and S_EMIT give one result per held entry
// throughput: one transaction at a time; o_stall stays high outside S_IDLE, held entries
//   are read through the registered memory, and output stalls hold S_EMIT and S_LAST back
// reset: synchronous active low; last stamp returns to the all-ones sentinel, store empty
module duplicate_timestamp_interpolator import dti_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,

    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_op,
    input  logic [STAMP_W-1:0] i_time_stamp,
    input  logic [POS_W-1:0]   i_buffer_pos,
    input  logic [SIZE_W-1:0]  i_frame_size,
    input  logic               i_key_frame,

    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [STAMP_W-1:0] o_out_time_stamp,
    output logic [POS_W-1:0]   o_out_buffer_pos,
    output logic [SIZE_W-1:0]  o_out_frame_size,
    output logic               o_out_key_frame,
    output logic               o_status,
    output logic               o_last
);

    // control state
    t_state             r_state, n_state;
    logic [STAMP_W-1:0] r_last_ts, n_last_ts;   // sentinel when no valid stamp yet
    logic [CNT_W-1:0]   r_cnt, n_cnt;           // number of held entries
    logic [IDX_W-1:0]   r_idx, n_idx;           // held entry being emitted
    logic               r_drop, n_drop;         // current transaction is a drop echo
    logic               r_up, n_up;             // new stamp above the last valid one
    logic               r_out_valid, n_out_valid;

    // payload
    logic [STAMP_W-1:0] r_in_ts, n_in_ts;
    t_held              r_in_ent, n_in_ent;
    logic [STAMP_W-1:0] r_step, n_step;         // spacing between spread stamps
    logic [STAMP_W-1:0] r_off, n_off;           // running i * step
    logic [STAMP_W-1:0] r_o_ts, n_o_ts;
    t_held              r_o_ent, n_o_ent;
    logic               r_o_status, n_o_status;
    logic               r_o_last, n_o_last;

    // helpers
    logic               ts_eq, at_sentinel, store_full, in_up, out_free;
    logic [STAMP_W-1:0] stamp_gap;

    // memory and divider hookup
    logic               mem_wr_en;
    t_held              mem_wr_data;
    t_held              mem_rd_data;
    logic               div_start;
    logic               div_done;
    logic [STAMP_W-1:0] div_quo;
    logic [DVS_W-1:0]   div_dvs;

    assign ts_eq       = (i_time_stamp == r_last_ts);
    assign at_sentinel = (r_last_ts == STAMP_SENTINEL);
    assign store_full  = (r_cnt == CNT_W'(HELD_DEPTH));
    assign in_up       = (i_time_stamp > r_last_ts);
    // magnitude of the stamp jump, direction taken from the compare
    assign stamp_gap   = in_up ? (i_time_stamp - r_last_ts) : (r_last_ts - i_time_stamp);
    // divisor is held count plus one
    assign div_dvs     = DVS_W'(r_cnt) + DVS_W'(1);
    assign out_free    = !r_out_valid || !i_stall;

    assign mem_wr_data = '{pos: i_buffer_pos, size: i_frame_size, key: i_key_frame};

    dti_held_mem u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_cnt[IDX_W-1:0]),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (mem_rd_data)
    );

    dti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (stamp_gap),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // sequencer: next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_last_ts   = r_last_ts;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_drop      = r_drop;
        n_up        = r_up;
        n_in_ts     = r_in_ts;
        n_in_ent    = r_in_ent;
        n_step      = r_step;
        n_off       = r_off;
        n_o_ts      = r_o_ts;
        n_o_ent     = r_o_ent;
        n_o_status  = r_o_status;
        n_o_last    = r_o_last;
        // result leaves when the downstream side takes it
        n_out_valid = r_out_valid && i_stall;
        mem_wr_en   = 1'b0;
        div_start   = 1'b0;
        o_stall     = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_in_ts  = i_time_stamp;
                    n_in_ent = mem_wr_data;
                    if (i_op == OP_FLUSH) begin
                        // drop held entries, back to the sentinel
                        n_cnt     = '0;
                        n_last_ts = STAMP_SENTINEL;
                    end else if (ts_eq) begin
                        if (at_sentinel || store_full) begin
                            // repeated sentinel or no room: echo as dropped
                            n_drop  = 1'b1;
                            n_state = S_LAST;
                        end else begin
                            mem_wr_en = 1'b1;
                            n_cnt     = r_cnt + CNT_W'(1);
                        end
                    end else begin
                        n_drop = 1'b0;
                        n_up   = in_up;
                        if (r_cnt != '0) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            n_state = S_LAST;
                        end
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_step  = div_quo;
                    n_off   = div_quo;
                    n_idx   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                // memory read of r_idx lands next cycle
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_ts      = r_up ? (r_last_ts + r_off) : (r_last_ts - r_off);
                    n_o_ent     = mem_rd_data;
                    n_o_status  = STATUS_OK;
                    n_o_last    = 1'b0;
                    n_idx       = r_idx + IDX_W'(1);
                    n_off       = r_off + r_step;
                    if (CNT_W'(r_idx) + CNT_W'(1) == r_cnt) begin
                        n_state = S_LAST;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_LAST: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_ts      = r_in_ts;
                    n_o_ent     = r_in_ent;
                    n_o_status  = r_drop ? STATUS_DROP : STATUS_OK;
                    n_o_last    = 1'b1;
                    if (!r_drop) begin
                        // new entry becomes the reference stamp
                        n_last_ts = r_in_ts;
                        n_cnt     = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_ts   <= STAMP_SENTINEL;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_drop      <= 1'b0;
            r_up        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_ts   <= n_last_ts;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_drop      <= n_drop;
            r_up        <= n_up;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_ts    <= n_in_ts;
        r_in_ent   <= n_in_ent;
        r_step     <= n_step;
        r_off      <= n_off;
        r_o_ts     <= n_o_ts;
        r_o_ent    <= n_o_ent;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_valid          = r_out_valid;
    assign o_out_time_stamp = r_o_ts;
    assign o_out_buffer_pos = r_o_ent.pos;
    assign o_out_frame_size = r_o_ent.size;
    assign o_out_key_frame  = r_o_ent.key;
    assign o_status         = r_o_status;
    assign o_last           = r_o_last;

    // held count stays within the store
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(HELD_DEPTH))
        else $error("held count beyond store depth");

    // a dropped entry is always the final result of its transaction
    a_drop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_DROP) |-> o_last)
        else $error("drop result not marked last");

    // the divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide wait");

    // emission only starts from a nonempty store
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (r_cnt != '0))
        else $error("emitting from empty store");

endmodule
